[design/afsr_pkg.sv]
// Package with the shared types and constants of the frame skip regulator.
`timescale 1ns / 1ps

package afsr_pkg;

  // Saturation limits of the frame counters and the wait count.
  localparam logic [9:0] COUNT_MAX = 10'd1023;
  localparam logic [7:0] WAIT_MAX  = 8'd255;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TARGET_RATE = 2'd0;
  localparam logic [1:0] CFG_SKIP_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_WAIT_ENABLE = 2'd2;

  // Configuration register reset values.
  localparam logic [7:0] TARGET_RATE_RST = 8'd0;
  localparam logic [3:0] SKIP_LIMIT_RST  = 4'd5;
  localparam logic       WAIT_ENABLE_RST = 1'b1;

  // Current configuration.
  typedef struct packed {
    logic [7:0] target_rate;
    logic [3:0] skip_limit;
    logic       wait_enable;
  } afsr_cfg_t;

  // Event raised when the skip limit is written, so the skip amount can be clamped.
  typedef struct packed {
    logic       limit_wr;
    logic [3:0] limit_val;
  } afsr_cfg_wr_t;

  // Regulator state carried from one frame to the next.
  typedef struct packed {
    logic [3:0]  skip_left;
    logic [3:0]  skip_now;
    logic [9:0]  second_frames;
    logic [9:0]  shown_rate;
    logic [31:0] second_mark;
    logic [9:0]  tenth_frames;
    logic [31:0] tenth_mark;
    logic [7:0]  wait_count;
  } afsr_state_t;

  // One result item.
  typedef struct packed {
    logic       draw_frame;
    logic [9:0] rate_value;
    logic [3:0] skip_amount;
    logic [7:0] wait_amount;
    logic [7:0] sleep_ticks;
  } afsr_result_t;

endpackage

[design/afsr_cfg_regs.sv]
// Configuration registers of the frame skip regulator.
`timescale 1ns / 1ps

module afsr_cfg_regs
  import afsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  output afsr_cfg_t    cfg,
  output afsr_cfg_wr_t cfg_wr
);

  afsr_cfg_t cfg_r;
  afsr_cfg_t cfg_nxt;
  logic      wr_en;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid;

  // Decode the register index; an unknown index leaves every register alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index)
        CFG_TARGET_RATE: cfg_nxt.target_rate = cfg_data;
        CFG_SKIP_LIMIT:  cfg_nxt.skip_limit  = cfg_data[3:0];
        CFG_WAIT_ENABLE: cfg_nxt.wait_enable = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_rate <= TARGET_RATE_RST;
      cfg_r.skip_limit  <= SKIP_LIMIT_RST;
      cfg_r.wait_enable <= WAIT_ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Tell the state logic about a skip limit write in the same cycle.
  assign cfg_wr.limit_wr  = wr_en && (cfg_index == CFG_SKIP_LIMIT);
  assign cfg_wr.limit_val = cfg_data[3:0];
  assign cfg              = cfg_r;

endmodule

[design/afsr_step.sv]
// Per-frame decision logic: draw decision, rate windows and skip/wait regulation.
`timescale 1ns / 1ps

module afsr_step
  import afsr_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  afsr_state_t  state,
  input  afsr_cfg_t    cfg,
  input  logic [31:0]  tick_now,
  output afsr_state_t  state_nxt,
  output afsr_result_t result
);

  localparam logic [31:0] SECOND_TICKS = 32'(TICKS_PER_SECOND);
  localparam logic [31:0] TENTH_TICKS  = 32'(TICKS_PER_SECOND / 10);

  logic        draw;
  logic [9:0]  sf_inc;
  logic [9:0]  tf_inc;
  logic [31:0] sec_delta;
  logic [31:0] tenth_delta;
  logic        sec_hit;
  logic        tenth_hit;
  logic [13:0] rate10;
  logic        too_slow;
  logic        too_fast;
  logic        reg_on;

  // Saturating frame counts and wrapped tick distances.
  assign draw        = (state.skip_left == 4'd0);
  assign sf_inc      = (state.second_frames < COUNT_MAX) ? state.second_frames + 10'd1 : COUNT_MAX;
  assign tf_inc      = (state.tenth_frames < COUNT_MAX) ? state.tenth_frames + 10'd1 : COUNT_MAX;
  assign sec_delta   = tick_now - state.second_mark;
  assign tenth_delta = tick_now - state.tenth_mark;
  assign sec_hit     = (sec_delta >= SECOND_TICKS);
  assign tenth_hit   = (tenth_delta >= TENTH_TICKS);
  assign reg_on      = (cfg.target_rate != 8'd0);

  // Ten times the frames of the tenth, as shift and add.
  assign rate10   = {1'b0, tf_inc, 3'b000} + {3'b000, tf_inc, 1'b0};
  assign too_slow = (rate10 < {6'd0, cfg.target_rate});
  assign too_fast = (rate10 > {6'd0, cfg.target_rate});

  always_comb begin
    state_nxt = state;

    // One-second rate window.
    if (sec_hit) begin
      state_nxt.second_mark   = tick_now;
      state_nxt.shown_rate    = sf_inc;
      state_nxt.second_frames = 10'd0;
    end else begin
      state_nxt.second_frames = sf_inc;
    end

    // Skip countdown reloads from the skip amount held before regulation.
    if (draw) begin
      state_nxt.skip_left = state.skip_now;
    end else begin
      state_nxt.skip_left = state.skip_left - 4'd1;
    end

    // Tenth-second regulation, only with a target set.
    if (reg_on) begin
      if (!tenth_hit) begin
        state_nxt.tenth_frames = tf_inc;
      end else begin
        state_nxt.tenth_mark   = tick_now;
        state_nxt.tenth_frames = 10'd0;
        if (too_slow) begin
          if (state.wait_count != 8'd0) begin
            state_nxt.wait_count = state.wait_count - 8'd1;
          end else if (state.skip_now < cfg.skip_limit) begin
            state_nxt.skip_now = state.skip_now + 4'd1;
          end
        end else if (too_fast) begin
          if (state.skip_now != 4'd0) begin
            state_nxt.skip_now = state.skip_now - 4'd1;
          end else if (cfg.wait_enable) begin
            state_nxt.wait_count = (state.wait_count < WAIT_MAX) ?
                                   state.wait_count + 8'd1 : WAIT_MAX;
          end
        end
      end
    end
  end

  // Result fields come from the updated state; the draw decision comes from the state before it.
  always_comb begin
    result.draw_frame  = draw;
    result.rate_value  = state_nxt.shown_rate;
    result.skip_amount = state_nxt.skip_now;
    result.wait_amount = state_nxt.wait_count;
    if (reg_on && cfg.wait_enable && (state_nxt.wait_count != 8'd0)) begin
      result.sleep_ticks = state_nxt.wait_count - 8'd1;
    end else begin
      result.sleep_ticks = 8'd0;
    end
  end

endmodule

[design/adaptive_frame_skip_regulator_top.sv]
// Top level of the adaptive frame skip regulator.
`timescale 1ns / 1ps

// Usage:
// One input transfer per finished frame carries the tick count at the end of
// that frame. Each input transfer yields exactly one result transfer with the
// draw decision, the rate of the last full second, the skip amount, the wait
// count and the sleep length, in input order.
// Configuration writes use their own channel, index 0 target rate, 1 skip
// limit, 2 wait enable; other indexes are ignored. cfg_ready is always high.
// Write configuration only while no frame is in flight.
// Each accepted item passes through the input register and then the output
// registers. Throughput: one item per cycle while the receiver takes results;
// the state registers close the frame-to-frame loop between consecutive items.
// The input register and the output register each hold one item; when the
// receiver stalls, both fill and in_ready drops until out_ready returns.
// Reset (synchronous, active low) clears all regulator state and the
// pipeline, and restores target rate 0, skip limit 5 and wait enable 1.

module adaptive_frame_skip_regulator_top
  import afsr_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_tick_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_draw_frame,
  output logic [9:0]  out_rate_value,
  output logic [3:0]  out_skip_amount,
  output logic [7:0]  out_wait_amount,
  output logic [7:0]  out_sleep_ticks,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  afsr_cfg_t    cfg;
  afsr_cfg_wr_t cfg_wr;
  afsr_state_t  state_r;
  afsr_state_t  state_nxt;
  afsr_state_t  step_state;
  afsr_result_t step_result;
  afsr_result_t result_r;
  logic         s1_valid_r;
  logic [31:0]  s1_tick_r;
  logic         out_valid_r;
  logic         advance;

  afsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr)
  );

  afsr_step #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_step (
    .state     (state_r),
    .cfg       (cfg),
    .tick_now  (s1_tick_r),
    .state_nxt (step_state),
    .result    (step_result)
  );

  // The output register can take a new result when empty or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tick_r <= in_tick_now;
    end
  end

  // State update on each processed frame, and skip clamp on a limit write.
  always_comb begin
    state_nxt = state_r;
    if (s1_valid_r && advance) begin
      state_nxt = step_state;
    end
    if (cfg_wr.limit_wr && (state_nxt.skip_now > cfg_wr.limit_val)) begin
      state_nxt.skip_now = cfg_wr.limit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      result_r <= step_result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_draw_frame  = result_r.draw_frame;
  assign out_rate_value  = result_r.rate_value;
  assign out_skip_amount = result_r.skip_amount;
  assign out_wait_amount = result_r.wait_amount;
  assign out_sleep_ticks = result_r.sleep_ticks;

  // The skip amount never exceeds the configured limit.
  a_skip_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.skip_now <= cfg.skip_limit)
    else $error("skip amount above skip limit");

  // A nonzero reported sleep is one less than the reported wait count.
  a_sleep_matches_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (result_r.sleep_ticks != 8'd0) |->
    result_r.wait_amount == result_r.sleep_ticks + 8'd1)
    else $error("sleep length does not match wait count");

  // A frame leaving the input register shows up on the output next cycle.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance |=> out_valid_r)
    else $error("processed frame lost between stages");

  // Input backpressure only when both registers are occupied.
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free pipeline space");

endmodule
